>>> rtl/mle_pkg.sv
// Shared constants and types of the matrix layout engine.
// Used by matrix_layout_engine; depends on nothing.
package mle_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int DIM_W = 11;
  localparam int ELEM_W = 32;
  localparam int PROD_W = 24;
  localparam logic [DIM_W-1:0] DIM_MAX = '1;

  localparam logic [3:0] MODE_SET_SHAPE  = 4'd0;
  localparam logic [3:0] MODE_RAVEL      = 4'd1;
  localparam logic [3:0] MODE_RESHAPE    = 4'd2;
  localparam logic [3:0] MODE_RESIZE     = 4'd3;
  localparam logic [3:0] MODE_APPEND_ROW = 4'd4;
  localparam logic [3:0] MODE_INSERT_ROW = 4'd5;
  localparam logic [3:0] MODE_APPEND_COL = 4'd6;
  localparam logic [3:0] MODE_INSERT_COL = 4'd7;
  localparam logic [3:0] MODE_DELETE_ROW = 4'd8;
  localparam logic [3:0] MODE_DELETE_COL = 4'd9;
  localparam logic [3:0] MODE_TILE       = 4'd10;
  localparam logic [3:0] MODE_TRANSPOSE  = 4'd11;
  localparam logic [3:0] MODE_DATA       = 4'd12;
  localparam logic [3:0] MODE_READ       = 4'd13;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CAPACITY = 3'd1;
  localparam logic [2:0] ST_BAD_IDX  = 3'd2;
  localparam logic [2:0] ST_UNEXP    = 3'd3;
  localparam logic [2:0] ST_PENDING  = 3'd4;
  localparam logic [2:0] ST_MISMATCH = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_ROW  = 2'd2,
    KIND_COL  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_EXEC,
    S_COPY,
    S_BUILD,
    S_DONE
  } state_t;

endpackage

>>> rtl/matrix_layout_engine.sv
// Matrix layout engine top level: command sequencer around two 1024-entry memories.
// Depends on mle_pkg.
//
// Usage: an item (in_mode, in_arg_a, in_arg_b, in_value) is taken at a rising
// edge where start is high and busy is low. Exactly one result follows, shown
// for one cycle with out_valid high; the receiver cannot stall it.
// Every item first forms its size products through one shared multiplier,
// then decides, then presents the result; data, read and simple shape items
// go straight from deciding to the result.
// When they succeed, resize, row and column append, insert or delete, tile and
// transpose first copy the old elements from the element memory into a scratch
// memory, one per cycle, then rebuild the element memory from the scratch
// memory, one destination per cycle through the scratch read port.
// A new item is taken only once the previous result has been shown.
// Reset clears the shape and any pending fill; the memories are not cleared.
// The user must read an element only after it was written; the block does not enforce it.
module matrix_layout_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    in_mode,
  input  logic [mle_pkg::DIM_W-1:0]     in_arg_a,
  input  logic [mle_pkg::DIM_W-1:0]     in_arg_b,
  input  logic [mle_pkg::ELEM_W-1:0]    in_value,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [mle_pkg::DIM_W-1:0]     out_row_total,
  output logic [mle_pkg::DIM_W-1:0]     out_column_total,
  output logic [mle_pkg::ELEM_W-1:0]    out_read_value,
  output logic [mle_pkg::DIM_W-1:0]     out_fill_left
);
  import mle_pkg::*;

  state_t state_r, state_nxt;

  logic [3:0]        mode_r;
  logic [DIM_W-1:0]  a_r, b_r;
  logic [ELEM_W-1:0] val_r;
  logic [DIM_W-1:0]  rows_r, cols_r, cur_r;
  logic [DIM_W-1:0]  orows_r, ocols_r, ocur_r;
  kind_t             pk_r;
  logic [DIM_W-1:0]  pcnt_r, ptgt_r, ppos_r;
  logic [1:0]        step_r;
  logic [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic [2:0]        st_r;
  logic [DIM_W-1:0]  idx_r;

  logic [DIM_W-1:0]  cc_r, bd_r, bi_r, bj_r, rm_r, cm_r;
  logic              cv_r, bv_r, bz_r;
  logic [ADDR_W-1:0] cad_r, bdd_r;

  logic [ELEM_W-1:0] emem [MAX_ELEMENTS];
  logic [ELEM_W-1:0] smem [MAX_ELEMENTS];
  logic [ELEM_W-1:0] e_q, s_q;

  logic [11:0]       mul_x, mul_y;
  logic [PROD_W-1:0] mul_p;

  logic [2:0]        ex_st;
  logic [DIM_W-1:0]  ex_nr, ex_nc, ex_cur, ex_idx;
  logic              ex_pass, ex_fill, ex_upd;
  kind_t             ex_fkind;
  logic [DIM_W-1:0]  ex_ftgt, ex_fcnt;
  logic              fits0;
  logic [DIM_W-1:0]  data_add;
  logic [PROD_W:0]   dix;

  logic              e_re, e_we, s_re;
  logic [ADDR_W-1:0] e_ra, e_wa, s_ra;
  logic [ELEM_W-1:0] e_wd;

  logic              copy_issue, build_issue;
  logic [DIM_W-1:0]  sr, sc;
  logic              src_zero;
  logic [21:0]       src_prod;
  logic [ADDR_W-1:0] src_addr;

  // Shared size multiplier.
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (step_r)
      2'd0: begin
        unique case (mode_r)
          MODE_SET_SHAPE, MODE_RESHAPE, MODE_RESIZE: begin
            mul_x = {1'b0, a_r};
            mul_y = {1'b0, b_r};
          end
          MODE_APPEND_ROW, MODE_INSERT_ROW: begin
            mul_x = {1'b0, rows_r} + 12'd1;
            mul_y = {1'b0, cols_r};
          end
          MODE_APPEND_COL, MODE_INSERT_COL: begin
            mul_x = {1'b0, rows_r};
            mul_y = {1'b0, cols_r} + 12'd1;
          end
          MODE_TILE: begin
            mul_x = {1'b0, rows_r};
            mul_y = {1'b0, a_r};
          end
          MODE_DATA: begin
            mul_x = (pk_r == KIND_ROW) ? {1'b0, ptgt_r} :
                    (pk_r == KIND_COL) ? {1'b0, ppos_r} : 12'd0;
            mul_y = {1'b0, cols_r};
          end
          default: begin
            mul_x = '0;
            mul_y = '0;
          end
        endcase
      end
      2'd1: begin
        mul_x = {1'b0, cols_r};
        mul_y = {1'b0, b_r};
      end
      default: begin
        mul_x = {1'b0, p0_r[DIM_W-1:0]};
        mul_y = {1'b0, p1_r[DIM_W-1:0]};
      end
    endcase
    mul_p = mul_x * mul_y;
  end

  // Command decision.
  always_comb begin
    fits0    = p0_r <= PROD_W'(MAX_ELEMENTS);
    ex_st    = ST_OK;
    ex_nr    = rows_r;
    ex_nc    = cols_r;
    ex_cur   = cur_r;
    ex_idx   = a_r;
    ex_pass  = 1'b0;
    ex_fill  = 1'b0;
    ex_upd   = 1'b0;
    ex_fkind = KIND_NONE;
    ex_ftgt  = '0;
    ex_fcnt  = '0;
    data_add = (pk_r == KIND_COL) ? ptgt_r : ppos_r;
    dix      = {1'b0, p0_r} + (PROD_W + 1)'(data_add);
    if (mode_r == MODE_DATA) begin
      if (pk_r == KIND_NONE) ex_st = ST_UNEXP;
    end else if (mode_r == MODE_READ) begin
      if (a_r >= cur_r) ex_st = ST_BAD_IDX;
    end else if (mode_r > MODE_READ) begin
      ex_st = ST_OK;
    end else if (pk_r != KIND_NONE) begin
      ex_st = ST_PENDING;
    end else begin
      unique case (mode_r)
        MODE_SET_SHAPE: begin
          if (!fits0) begin
            ex_st = ST_CAPACITY;
          end else begin
            ex_upd   = 1'b1;
            ex_nr    = a_r;
            ex_nc    = b_r;
            ex_cur   = p0_r[DIM_W-1:0];
            ex_fill  = 1'b1;
            ex_fkind = KIND_LOAD;
            ex_fcnt  = p0_r[DIM_W-1:0];
          end
        end
        MODE_RAVEL: begin
          ex_upd = 1'b1;
          ex_nr  = DIM_W'(1);
          ex_nc  = cur_r;
        end
        MODE_RESHAPE: begin
          if (p0_r != PROD_W'(cur_r)) begin
            ex_st = ST_MISMATCH;
          end else begin
            ex_upd = 1'b1;
            ex_nr  = a_r;
            ex_nc  = b_r;
          end
        end
        MODE_RESIZE: begin
          if (!fits0) begin
            ex_st = ST_CAPACITY;
          end else if (cur_r == '0 && p0_r != '0) begin
            ex_st = ST_EMPTY;
          end else begin
            ex_upd  = 1'b1;
            ex_pass = 1'b1;
            ex_nr   = a_r;
            ex_nc   = b_r;
            ex_cur  = p0_r[DIM_W-1:0];
          end
        end
        MODE_APPEND_ROW, MODE_INSERT_ROW: begin
          ex_idx = (mode_r == MODE_APPEND_ROW) ? rows_r : a_r;
          if (mode_r == MODE_INSERT_ROW && a_r > rows_r) begin
            ex_st = ST_BAD_IDX;
          end else if (rows_r == DIM_MAX || !fits0) begin
            ex_st = ST_CAPACITY;
          end else begin
            ex_upd   = 1'b1;
            ex_pass  = 1'b1;
            ex_nr    = rows_r + DIM_W'(1);
            ex_cur   = p0_r[DIM_W-1:0];
            ex_fill  = 1'b1;
            ex_fkind = KIND_ROW;
            ex_ftgt  = ex_idx;
            ex_fcnt  = cols_r;
          end
        end
        MODE_APPEND_COL, MODE_INSERT_COL: begin
          ex_idx = (mode_r == MODE_APPEND_COL) ? cols_r : a_r;
          if (mode_r == MODE_INSERT_COL && a_r > cols_r) begin
            ex_st = ST_BAD_IDX;
          end else if (cols_r == DIM_MAX || !fits0) begin
            ex_st = ST_CAPACITY;
          end else begin
            ex_upd   = 1'b1;
            ex_pass  = 1'b1;
            ex_nc    = cols_r + DIM_W'(1);
            ex_cur   = p0_r[DIM_W-1:0];
            ex_fill  = 1'b1;
            ex_fkind = KIND_COL;
            ex_ftgt  = ex_idx;
            ex_fcnt  = rows_r;
          end
        end
        MODE_DELETE_ROW: begin
          if (a_r >= rows_r) begin
            ex_st = ST_BAD_IDX;
          end else begin
            ex_upd  = 1'b1;
            ex_pass = 1'b1;
            ex_nr   = rows_r - DIM_W'(1);
            ex_cur  = cur_r - cols_r;
          end
        end
        MODE_DELETE_COL: begin
          if (a_r >= cols_r) begin
            ex_st = ST_BAD_IDX;
          end else begin
            ex_upd  = 1'b1;
            ex_pass = 1'b1;
            ex_nc   = cols_r - DIM_W'(1);
            ex_cur  = cur_r - rows_r;
          end
        end
        MODE_TILE: begin
          if (p0_r > PROD_W'(DIM_MAX) || p1_r > PROD_W'(DIM_MAX) ||
              p2_r > PROD_W'(MAX_ELEMENTS)) begin
            ex_st = ST_CAPACITY;
          end else begin
            ex_upd  = 1'b1;
            ex_pass = 1'b1;
            ex_nr   = p0_r[DIM_W-1:0];
            ex_nc   = p1_r[DIM_W-1:0];
            ex_cur  = p2_r[DIM_W-1:0];
          end
        end
        default: begin
          ex_upd  = 1'b1;
          ex_pass = 1'b1;
          ex_nr   = cols_r;
          ex_nc   = rows_r;
        end
      endcase
    end
  end

  // Rebuild source address for the current destination element.
  always_comb begin
    sr       = bi_r;
    sc       = bj_r;
    src_zero = 1'b0;
    unique case (mode_r)
      MODE_APPEND_ROW, MODE_INSERT_ROW: begin
        src_zero = bi_r == idx_r;
        sr       = (bi_r < idx_r) ? bi_r : bi_r - DIM_W'(1);
      end
      MODE_DELETE_ROW: sr = (bi_r < idx_r) ? bi_r : bi_r + DIM_W'(1);
      MODE_APPEND_COL, MODE_INSERT_COL: begin
        src_zero = bj_r == idx_r;
        sc       = (bj_r < idx_r) ? bj_r : bj_r - DIM_W'(1);
      end
      MODE_DELETE_COL: sc = (bj_r < idx_r) ? bj_r : bj_r + DIM_W'(1);
      MODE_TILE: begin
        sr = rm_r;
        sc = cm_r;
      end
      MODE_TRANSPOSE: begin
        sr = bj_r;
        sc = bi_r;
      end
      default: begin
        sr = '0;
        sc = cm_r;
      end
    endcase
    src_prod = sr * ocols_r;
    src_addr = src_prod[ADDR_W-1:0] + sc[ADDR_W-1:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_CALC;
      S_CALC:  if (step_r == 2'd2) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = (ex_pass && ex_st == ST_OK) ? S_COPY : S_DONE;
      S_COPY:  if (cc_r == ocur_r && !cv_r) state_nxt = S_BUILD;
      S_BUILD: if (bd_r == cur_r && !bv_r) state_nxt = S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    busy        = state_r != S_IDLE;
    out_valid   = state_r == S_DONE;
    copy_issue  = state_r == S_COPY && cc_r != ocur_r;
    build_issue = state_r == S_BUILD && bd_r != cur_r;
    e_re        = copy_issue || (state_r == S_EXEC && mode_r == MODE_READ);
    e_ra        = copy_issue ? cc_r[ADDR_W-1:0] : a_r[ADDR_W-1:0];
    s_re        = build_issue;
    s_ra        = src_addr;
    e_we        = 1'b0;
    e_wa        = dix[ADDR_W-1:0];
    e_wd        = val_r;
    if (state_r == S_BUILD && bv_r) begin
      e_we = 1'b1;
      e_wa = bdd_r;
      e_wd = bz_r ? '0 : s_q;
    end else if (state_r == S_EXEC && mode_r == MODE_DATA && ex_st == ST_OK &&
                 dix < (PROD_W + 1)'(MAX_ELEMENTS)) begin
      e_we = 1'b1;
    end
  end

  assign out_status       = st_r;
  assign out_row_total    = rows_r;
  assign out_column_total = cols_r;
  assign out_fill_left    = pcnt_r;
  assign out_read_value   = (mode_r == MODE_READ && st_r == ST_OK) ? e_q : '0;

  always_ff @(posedge clk) begin
    if (e_we) emem[e_wa] <= e_wd;
    if (e_re) e_q <= emem[e_ra];
    if (cv_r) smem[cad_r] <= e_q;
    if (s_re) s_q <= smem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rows_r  <= '0;
      cols_r  <= '0;
      cur_r   <= '0;
      pk_r    <= KIND_NONE;
      pcnt_r  <= '0;
      ptgt_r  <= '0;
      ppos_r  <= '0;
      step_r  <= '0;
      cv_r    <= 1'b0;
      bv_r    <= 1'b0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      cv_r    <= copy_issue;
      bv_r    <= build_issue;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r <= in_mode;
            a_r    <= in_arg_a;
            b_r    <= in_arg_b;
            val_r  <= in_value;
            step_r <= '0;
          end
        end
        S_CALC: begin
          step_r <= step_r + 2'd1;
          unique case (step_r)
            2'd0:    p0_r <= mul_p;
            2'd1:    p1_r <= mul_p;
            default: p2_r <= mul_p;
          endcase
        end
        S_EXEC: begin
          st_r    <= ex_st;
          idx_r   <= ex_idx;
          orows_r <= rows_r;
          ocols_r <= cols_r;
          ocur_r  <= cur_r;
          cc_r    <= '0;
          bd_r    <= '0;
          bi_r    <= '0;
          bj_r    <= '0;
          rm_r    <= '0;
          cm_r    <= '0;
          if (ex_st == ST_OK && ex_upd) begin
            rows_r <= ex_nr;
            cols_r <= ex_nc;
            cur_r  <= ex_cur;
          end
          if (ex_st == ST_OK && ex_fill) begin
            pk_r   <= (ex_fcnt == '0) ? KIND_NONE : ex_fkind;
            ptgt_r <= ex_ftgt;
            ppos_r <= '0;
            pcnt_r <= ex_fcnt;
          end
          if (mode_r == MODE_DATA && ex_st == ST_OK) begin
            ppos_r <= ppos_r + DIM_W'(1);
            pcnt_r <= pcnt_r - DIM_W'(1);
            if (pcnt_r == DIM_W'(1)) pk_r <= KIND_NONE;
          end
        end
        S_COPY: begin
          cad_r <= cc_r[ADDR_W-1:0];
          if (copy_issue) cc_r <= cc_r + DIM_W'(1);
        end
        S_BUILD: begin
          bdd_r <= bd_r[ADDR_W-1:0];
          bz_r  <= src_zero;
          if (build_issue) begin
            bd_r <= bd_r + DIM_W'(1);
            if (mode_r == MODE_RESIZE) begin
              cm_r <= (cm_r + DIM_W'(1) == ocur_r) ? '0 : cm_r + DIM_W'(1);
            end else begin
              cm_r <= (cm_r + DIM_W'(1) == ocols_r) ? '0 : cm_r + DIM_W'(1);
            end
            if (bj_r + DIM_W'(1) == cols_r) begin
              bj_r <= '0;
              bi_r <= bi_r + DIM_W'(1);
              rm_r <= (rm_r + DIM_W'(1) == orows_r) ? '0 : rm_r + DIM_W'(1);
            end else begin
              bj_r <= bj_r + DIM_W'(1);
            end
          end
        end
        default: begin
          step_r <= '0;
        end
      endcase
    end
  end

endmodule
